### src/ffwq_pkg.sv
// ffwq_pkg: word types, status codes and controller states of the first-fit waiting queue.
// Used by the top level, the engine and the bench (ffwq_ram does not use it); depends on nothing.
`default_nettype none

package ffwq_pkg;

  localparam int KEY_W  = 64;
  localparam int SIZE_W = 8;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 5;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  entry_key;
    logic [SIZE_W-1:0] size_value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  found_key;
    logic [SIZE_W-1:0] found_size;
    logic [OCC_W-1:0]  occupancy;
  } out_word_t;

  // One queue entry as held in the RAM
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } fsm_t;

  // Control from the top level to the engine
  typedef struct packed {
    logic start;
    logic res_take;
  } eng_ctl_t;

  // Status from the engine to the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_sts_t;

endpackage

`default_nettype wire

### src/first_fit_waiting_queue.sv
// first_fit_waiting_queue: top level; input handshake, result output register, engine instance.
// Depends on ffwq_pkg and ffwq_engine.
// Sequence from acceptance to out_valid:
//   insert: key scan, one entry per cycle, then append if no key matches;
//   removal: scan up to the hit, then compaction to the end;
//   full queue or empty queue: refused without a scan. One word at a time.
// Reset: queue empty, no word pending; RAM contents are left as they are and never used.
`default_nettype none

module first_fit_waiting_queue
  import ffwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  eng_ctl_t  ctl;
  eng_sts_t  sts;
  out_word_t eng_res;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  ffwq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .req   (in_word),
    .sts   (sts),
    .res   (eng_res)
  );

  assign in_stall     = !sts.idle;
  assign ctl.start    = in_valid && sts.idle;
  // Take the result when the output register is free or draining
  assign ctl.res_take = sts.res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_take) begin
      out_word_r <= eng_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.status <= ST_NO_FIT))
    else $error("result word with unknown status");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_REMOVED) |->
      (out_word_r.found_key == '0 && out_word_r.found_size == '0))
    else $error("found fields set without a removal");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_word_r))
    else $error("stalled result word overwritten");
`endif

endmodule

`default_nettype wire

### src/ffwq_ram.sv
// ffwq_ram: generic simple dual-port RAM, one write and one registered read port.
// Self-contained; no package needed.
`default_nettype none

module ffwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/ffwq_engine.sv
// ffwq_engine: sequencer that scans, appends to and compacts the queue held in the entry RAM.
// Depends on ffwq_pkg and ffwq_ram.
`default_nettype none

module ffwq_engine
  import ffwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire eng_ctl_t ctl,
  input  wire in_word_t req,
  output eng_sts_t      sts,
  output out_word_t     res
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  in_word_t          req_r, req_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  logic               ram_wen;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  logic               more;
  logic               hit;
  logic               refuse;

  ffwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wen),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (iss_r[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign more     = (iss_r < count_r);
  // Entry returned this cycle matches: equal key on insert, fits on removal
  assign hit      = pend_r && ((req_r.req_type == REQ_INSERT) ?
                               (rd_entry.key == req_r.entry_key) :
                               (rd_entry.size <= req_r.size_value));
  assign refuse   = ((req.req_type == REQ_INSERT) && (count_r == FULL_CNT)) ||
                    ((req.req_type == REQ_REMOVE) && (count_r == '0));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          state_nxt = refuse ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (req_r.req_type == REQ_INSERT) ? S_DONE : S_SHIFT;
        end else if (!more) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!pend_r && !more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (ctl.res_take) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_nxt  = count_r;
    iss_nxt    = iss_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    req_nxt    = req_r;
    status_nxt = status_r;
    key_nxt    = key_r;
    size_nxt   = size_r;
    ram_wen    = 1'b0;
    ram_waddr  = count_r[IDX_W-1:0];
    ram_wdata  = ram_rdata;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          req_nxt    = req;
          iss_nxt    = '0;
          pend_nxt   = 1'b0;
          key_nxt    = '0;
          size_nxt   = '0;
          status_nxt = (req.req_type == REQ_INSERT) ? ST_FULL : ST_EMPTY;
        end
      end
      S_SCAN: begin
        if (hit) begin
          pend_nxt = 1'b0;
          if (req_r.req_type == REQ_INSERT) begin
            status_nxt = ST_DUPLICATE;
          end else begin
            status_nxt = ST_REMOVED;
            key_nxt    = rd_entry.key;
            size_nxt   = rd_entry.size;
            iss_nxt    = CNT_W'(pidx_r) + CNT_W'(1);
          end
        end else if (more) begin
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[IDX_W-1:0];
          iss_nxt  = iss_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (req_r.req_type == REQ_INSERT) begin
            // Append as newest entry
            ram_wen    = 1'b1;
            ram_waddr  = count_r[IDX_W-1:0];
            ram_wdata  = {req_r.entry_key, req_r.size_value};
            count_nxt  = count_r + CNT_W'(1);
            status_nxt = ST_INSERTED;
          end else begin
            status_nxt = ST_NO_FIT;
          end
        end
      end
      S_SHIFT: begin
        // Move each younger entry up one place
        if (pend_r) begin
          ram_wen   = 1'b1;
          ram_waddr = pidx_r - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (more) begin
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[IDX_W-1:0];
          iss_nxt  = iss_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r    <= iss_nxt;
    pidx_r   <= pidx_nxt;
    req_r    <= req_nxt;
    status_r <= status_nxt;
    key_r    <= key_nxt;
    size_r   <= size_nxt;
  end

  assign sts.idle      = (state_r == S_IDLE);
  assign sts.res_valid = (state_r == S_DONE);

  assign res.status     = status_r;
  assign res.found_key  = key_r;
  assign res.found_size = size_r;
  assign res.occupancy  = OCC_W'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond queue depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wen |-> (CNT_W'(ram_waddr) < count_r) ||
                (state_r == S_SCAN && CNT_W'(ram_waddr) == count_r && count_r < FULL_CNT))
    else $error("RAM write outside the held entries");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wen |-> (state_r == S_SCAN || state_r == S_SHIFT))
    else $error("RAM write outside scan or shift");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(count_r))
    else $error("entry count changed while idle");

  a_removed_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && state_nxt == S_DONE) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("removal did not shrink the queue");
`endif

endmodule

`default_nettype wire

### bench/ffwq_checker.sv
`timescale 1ns / 100ps
// ffwq_checker: watches both channels of first_fit_waiting_queue, keeps its own copy of the
// queue to predict each result word, and compares the words field by field. Depends on ffwq_pkg.

module ffwq_checker
  import ffwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        mismatch_count,
  output int        pending_count
);

  // Oldest entry at index 0
  logic [KEY_W-1:0]  held_key [QUEUE_DEPTH];
  logic [SIZE_W-1:0] held_size[QUEUE_DEPTH];
  int                held_n = 0;
  out_word_t         pending_results[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Apply one request to the local queue and return the result word it gives.
  function automatic out_word_t serve_request(input in_word_t w);
    out_word_t r;
    logic      dup;
    int        hit;
    r   = '0;
    dup = 1'b0;
    if (w.req_type == REQ_INSERT) begin
      for (int i = 0; i < held_n; i++) begin
        if (held_key[i] == w.entry_key) dup = 1'b1;
      end
      // A full queue refuses the word even when its key is already held
      if (held_n >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else if (dup) begin
        r.status = ST_DUPLICATE;
      end else begin
        held_key[held_n]  = w.entry_key;
        held_size[held_n] = w.size_value;
        held_n++;
        r.status = ST_INSERTED;
      end
    end else if (held_n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      hit = held_n;
      // Walk from the newest so the oldest fit wins
      for (int i = held_n - 1; i >= 0; i--) begin
        if (held_size[i] <= w.size_value) hit = i;
      end
      if (hit == held_n) begin
        r.status = ST_NO_FIT;
      end else begin
        r.found_key  = held_key[hit];
        r.found_size = held_size[hit];
        for (int i = hit; i < held_n - 1; i++) begin
          held_key[i]  = held_key[i + 1];
          held_size[i] = held_size[i + 1];
        end
        held_n--;
        r.status = ST_REMOVED;
      end
    end
    r.occupancy = OCC_W'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      // Compare before predicting: a word accepted now cannot answer this edge
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing outstanding", out_word));
        end else begin
          want = pending_results.pop_front();
          if (out_word.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_word.status, want.status));
          if (out_word.found_key !== want.found_key)
            report_mismatch($sformatf("found_key %h, want %h",
                                      out_word.found_key, want.found_key));
          if (out_word.found_size !== want.found_size)
            report_mismatch($sformatf("found_size %0d, want %0d",
                                      out_word.found_size, want.found_size));
          if (out_word.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d",
                                      out_word.occupancy, want.occupancy));
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(serve_request(in_word));
      end
      pending_count = pending_results.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: bench top for first_fit_waiting_queue; clock, reset, request stimulus with idling phases
// and the verdict. Depends on ffwq_pkg, ffwq_checker and the block itself.

module tb;
  import ffwq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 1425;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int tx_idle_pct = 30;
  int rx_idle_pct = 49;
  int cycle_count = 0;
  int mismatch_count;
  int pending_count;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  first_fit_waiting_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  ffwq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("first_fit_waiting_queue verification failed");
      $finish;
    end
  end

  // Offer one word from a falling edge and hold it until the block takes it.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Keys mostly from a small pool so that duplicates come up often.
  function automatic in_word_t random_request(input int insert_pct);
    in_word_t         w;
    logic [KEY_W-1:0] k;
    logic [SIZE_W-1:0] s;
    if ($urandom_range(0, 99) < insert_pct) begin
      k = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : {$urandom, $urandom};
      s = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 15))
                                      : SIZE_W'($urandom_range(0, 255));
      w = in_word_t'{REQ_INSERT, k, s};
    end else begin
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = '1;
        default: s = SIZE_W'($urandom_range(0, 255));
      endcase
      w = in_word_t'{REQ_REMOVE, {$urandom, $urandom}, s};
    end
    return w;
  endfunction

  initial begin
    int insert_pct;
    insert_pct = 50;
    in_valid   = 1'b0;
    in_word    = '0;
    out_stall  = 1'b0;
    rst_n      = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(in_word_t'{REQ_REMOVE, '1, 8'd255});            // empty queue
    send_word(in_word_t'{REQ_INSERT, '0, 8'd0});
    send_word(in_word_t'{REQ_INSERT, '1, 8'd255});
    send_word(in_word_t'{REQ_INSERT, '0, 8'd5});              // duplicate key
    send_word(in_word_t'{REQ_REMOVE, '0, 8'd0});              // size zero fits zero capacity
    send_word(in_word_t'{REQ_REMOVE, '1, 8'd0});              // nothing fits
    send_word(in_word_t'{REQ_REMOVE, 64'h5555_aaaa_5555_aaaa, 8'd254});
    send_word(in_word_t'{REQ_REMOVE, '0, 8'd255});
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_word(in_word_t'{REQ_INSERT, 64'd1 << (i * 4), SIZE_W'(i * 17)});
    end
    // Held key on a full queue: full must win over duplicate
    send_word(in_word_t'{REQ_INSERT, 64'd1 << 12, 8'd1});

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 49 : 0;
      rx_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 30 : 0;
      for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
        // Swing the mix so the queue fills up and drains again
        if (n % 60 == 0) begin
          case ($urandom_range(0, 2))
            0: insert_pct = 25;
            1: insert_pct = 50;
            default: insert_pct = 80;
          endcase
        end
        send_word(random_request(insert_pct));
      end
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("first_fit_waiting_queue verification clean");
    end else begin
      $display("first_fit_waiting_queue verification failed");
    end
    $finish;
  end

endmodule
